// ===== design/s384_pkg.sv =====
// ----------------------------------------------------------------------------
// s384_pkg
// shared types, constants and round functions of the sha-384 engine
// ----------------------------------------------------------------------------
package s384_pkg;

  localparam int WordW      = 64;
  localparam int RoundsDef  = 80;
  localparam int DigestWrds = 6;

  typedef logic [WordW-1:0] word_t;

  localparam word_t MarkerWord = 64'h8000_0000_0000_0000;

  localparam word_t IV_TABLE [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam word_t K_TABLE [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // control from the sequencer to the round unit
  typedef struct packed {
    logic  push;       // shift a word into the schedule window
    word_t push_word;
    logic  start;      // load working variables from the hash state
    logic  round;      // run one round
    logic  add;        // fold working variables into the hash state
    logic  init;       // hash state back to the initial values
  } s384_ctl_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // keep the leading nb bytes, put the 0x80 marker right after them
  function automatic word_t pad_word(input word_t w, input logic [3:0] nb);
    word_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        r[63-8*i -: 8] = w[63-8*i -: 8];
      end else if (4'(i) == nb) begin
        r[63-8*i -: 8] = 8'h80;
      end
    end
    pad_word = r;
  endfunction

endpackage

// ===== design/s384_if.sv =====
// ----------------------------------------------------------------------------
// s384 channel interfaces
// valid/ready channels for message words and digest words
// ----------------------------------------------------------------------------
interface s384_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        final_word;

  modport source (output valid, message_word, valid_bytes, final_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface s384_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

// ===== design/s384_core.sv =====
// ----------------------------------------------------------------------------
// s384_core
// schedule window, working variables, hash state and the shared round unit
// ----------------------------------------------------------------------------
module s384_core #(
  parameter int ROUNDS = s384_pkg::RoundsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  s384_pkg::s384_ctl_t ctl,
  input  logic [2:0]          dig_sel,
  output logic                round_last,
  output s384_pkg::word_t     dig_word
);
  import s384_pkg::*;

  localparam int RndW = $clog2(ROUNDS);

  word_t           w_r    [16];
  word_t           v_r    [8];
  word_t           hash_r [8];
  logic [RndW-1:0] rnd_r;

  word_t t1, t2, ch, mj, w_new;

  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + bsig1(v_r[4]) + ch + K_TABLE[rnd_r] + w_r[0];
    t2    = bsig0(v_r[0]) + mj;
    w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  end

  assign round_last = (rnd_r == RndW'(ROUNDS - 1));
  assign dig_word   = hash_r[dig_sel];

  // schedule window: w_r[0] is the word of the current round
  always_ff @(posedge clk) begin
    if (ctl.push || ctl.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= ctl.push ? ctl.push_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) begin
        v_r[i]    <= '0;
        hash_r[i] <= IV_TABLE[i];
      end
    end else begin
      if (ctl.start) begin
        rnd_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
      end else if (ctl.round) begin
        rnd_r  <= rnd_r + 1'b1;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (ctl.init) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= IV_TABLE[i];
      end else if (ctl.add) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
      end
    end
  end

  start_clears_round : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> rnd_r == '0)
    else $error("round counter not cleared at block start");

  no_round_with_push : assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.round && ctl.push))
    else $error("schedule pushed during a round");

  no_init_with_add : assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.init && ctl.add))
    else $error("hash init collides with hash update");

endmodule

// ===== design/sha384_hash_top.sv =====
// ----------------------------------------------------------------------------
// sha384_hash_top
// sha-384 engine: 64-bit message words in, six 64-bit digest words out
// ----------------------------------------------------------------------------
// Message words arrive big-endian, one request per word; the word flagged
// final_word carries 0 to 8 valid leading bytes (above 8 counts as 8). A word
// is taken only while the engine is idle. Every sixteenth word starts
// a compression: 80 rounds on the single shared round unit, one round per
// cycle, then a fold of the result into the hash state in the S_ADD state.
// After the final word the sequencer pushes the marker word (if the final
// word was full), zero words and the length words, one per cycle between
// compressions, runs the one or two closing compressions, then delivers
// six digest requests, most significant word first, digest_last on the
// sixth; output backpressure only holds the result. After the sixth digest
// request the hash state, byte count and word position are reset for the
// next message. Input ready is low whenever the engine is compressing,
// padding or delivering a digest.
// ----------------------------------------------------------------------------
module sha384_hash_top #(
  parameter int ROUNDS = s384_pkg::RoundsDef
) (
  input  logic clk,
  input  logic rst_n,
  s384_in_if.sink    in_chan,
  s384_out_if.source out_chan
);
  import s384_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_OUT
  } state_t;

  state_t      state_r;
  logic [3:0]  slot_r;        // next free position in the block
  logic [63:0] count_r;       // message bytes, wraps mod 2^64
  logic        pad_mode_r;    // final word seen, padding in progress
  logic        marker_pend_r; // marker still owed as its own word
  logic        extra_r;       // marker landed in slot 14: one zero word first
  logic        len_done_r;    // length pushed, closing block under way
  logic [2:0]  idx_r;
  logic        out_valid_r;
  word_t       out_word_r;
  logic        out_last_r;

  s384_ctl_t ctl;
  logic      round_last;
  word_t     dig_word;

  logic       acc;
  logic [3:0] nb;
  word_t      pad_w;
  logic       pad_is_lo;

  assign acc = in_chan.valid && in_chan.ready;
  assign nb  = (in_chan.valid_bytes > 4'd8) ? 4'd8 : in_chan.valid_bytes;

  // word the padding sequencer pushes this cycle
  always_comb begin
    pad_is_lo = 1'b0;
    priority if (marker_pend_r) begin
      pad_w = MarkerWord;
    end else if (extra_r) begin
      pad_w = '0;
    end else if (slot_r == 4'd14) begin
      pad_w = {61'd0, count_r[63:61]};
    end else if (slot_r == 4'd15) begin
      pad_w     = {count_r[60:0], 3'b000};
      pad_is_lo = 1'b1;
    end else begin
      pad_w = '0;
    end
  end

  // control to the round unit
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          ctl.push = 1'b1;
          if (in_chan.final_word && nb != 4'd8) begin
            ctl.push_word = pad_word(in_chan.message_word, nb);
          end else begin
            ctl.push_word = in_chan.message_word;
          end
          ctl.start = (slot_r == 4'd15);
        end
      end
      S_ROUND: ctl.round = 1'b1;
      S_ADD:   ctl.add   = 1'b1;
      S_PAD: begin
        ctl.push      = 1'b1;
        ctl.push_word = pad_w;
        ctl.start     = (slot_r == 4'd15);
      end
      S_OUT: ctl.init = out_valid_r && out_chan.ready && out_last_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_r        <= '0;
      count_r       <= '0;
      pad_mode_r    <= 1'b0;
      marker_pend_r <= 1'b0;
      extra_r       <= 1'b0;
      len_done_r    <= 1'b0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            slot_r <= slot_r + 1'b1;
            if (in_chan.final_word) begin
              count_r    <= count_r + 64'(nb);
              pad_mode_r <= 1'b1;
              if (nb == 4'd8) begin
                marker_pend_r <= 1'b1;
              end else begin
                extra_r <= (slot_r == 4'd14);
              end
            end else begin
              count_r <= count_r + 64'd8;
            end
            if (slot_r == 4'd15) begin
              state_r <= S_ROUND;
            end else if (in_chan.final_word) begin
              state_r <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          if (round_last) state_r <= S_ADD;
        end
        S_ADD: begin
          if (len_done_r) begin
            state_r <= S_OUT;
            idx_r   <= '0;
          end else if (pad_mode_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PAD: begin
          slot_r <= slot_r + 1'b1;
          if (marker_pend_r) begin
            marker_pend_r <= 1'b0;
            extra_r       <= (slot_r == 4'd14);
          end else if (extra_r) begin
            extra_r <= 1'b0;
          end else if (pad_is_lo) begin
            len_done_r <= 1'b1;
          end
          if (slot_r == 4'd15) state_r <= S_ROUND;
        end
        S_OUT: begin
          if (out_valid_r && out_chan.ready && out_last_r) begin
            // digest delivered: fresh message
            out_valid_r <= 1'b0;
            out_last_r  <= 1'b0;
            slot_r      <= '0;
            count_r     <= '0;
            pad_mode_r  <= 1'b0;
            len_done_r  <= 1'b0;
            state_r     <= S_IDLE;
          end else if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_word_r  <= dig_word;
            out_last_r  <= (idx_r == 3'(DigestWrds - 1));
            idx_r       <= idx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  s384_core #(
    .ROUNDS(ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .dig_sel   (idx_r),
    .round_last(round_last),
    .dig_word  (dig_word)
  );

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.digest_last = out_last_r;

  out_only_in_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT)
    else $error("digest request outside delivery");

  no_ready_with_out : assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !out_valid_r)
    else $error("input ready while digest pending");

  last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && out_last_r) |=> (slot_r == '0 && count_r == '0))
    else $error("message state not cleared after digest");

  len_only_padding : assert property (@(posedge clk) disable iff (!rst_n)
    len_done_r |-> pad_mode_r)
    else $error("length pushed outside padding");

endmodule

// ===== tb/sha384_hash_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha384_hash_top_tb
// self-checking bench for the sha-384 engine: directed messages from a table,
// then random messages of random length, all digests checked against an
// in-bench software hash with random idling on both channels
// ----------------------------------------------------------------------------
module sha384_hash_top_tb;
  import s384_pkg::*;

  localparam int MaxIdleCycles = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  s384_in_if  in_chan ();
  s384_out_if out_chan ();

  sha384_hash_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // one digest word as it should come out
  typedef struct {
    logic [63:0] word;
    logic        last;
  } digest_exp_t;

  // one row of the directed table
  typedef struct {
    logic [63:0] msg;
    logic [3:0]  nbytes;
    logic        fin;
    logic [63:0] first_word;  // typed-in first digest word, checked if has_first
    logic        has_first;
  } stim_row_t;

  digest_exp_t digest_q[$];

  // predictor state
  logic [63:0] hstate [8];
  logic [63:0] blk [16];
  logic [63:0] byte_cnt;
  int unsigned slot;

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned digests_seen = 0;
  int unsigned messages_sent = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_tail = 1'b0;
  bit          hold_off = 1'b0;
  bit          first_check = 1'b0;
  logic [63:0] first_expect;

  function automatic logic [63:0] rr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // 80-round compression of the collected block into the hash state
  task automatic compress_blk();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] wt, t1, t2, a, b;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = hstate[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        a = w[(t - 15) & 15];
        b = w[(t - 2) & 15];
        wt = w[t & 15] + (rr(a, 1) ^ rr(a, 8) ^ (a >> 7)) + w[(t - 7) & 15]
           + (rr(b, 19) ^ rr(b, 61) ^ (b >> 6));
        w[t & 15] = wt;
      end
      t1 = v[7] + (rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[t] + wt;
      t2 = (rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hstate[i] += v[i];
  endtask

  task automatic stash_word(input logic [63:0] w);
    blk[slot] = w;
    slot = (slot + 1) & 15;
    if (slot == 0) compress_blk();
  endtask

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hstate[i] = IV_TABLE[i];
    byte_cnt = '0;
    slot = 0;
  endtask

  // predict the effect of one accepted request
  task automatic predict_word(input logic [63:0] msg, input logic [3:0] nb_in,
                              input logic fin);
    int unsigned nb;
    logic [63:0] keep;
    digest_exp_t e;
    if (!fin) begin
      byte_cnt += 8;
      stash_word(msg);
      return;
    end
    nb = (nb_in > 8) ? 8 : nb_in;
    byte_cnt += nb;
    if (nb == 8) begin
      stash_word(msg);
      stash_word(64'h8000_0000_0000_0000);
    end else begin
      keep = (nb == 0) ? 64'd0 : (~64'd0 << (64 - 8 * nb));
      stash_word((msg & keep) | (64'h80 << (56 - 8 * nb)));
    end
    // marker landed in slot 14: close the block first
    if (slot > 14) while (slot != 0) stash_word('0);
    while (slot < 14) stash_word('0);
    stash_word(byte_cnt >> 61);
    stash_word(byte_cnt << 3);
    for (int k = 0; k < 6; k++) begin
      e.word = hstate[k];
      e.last = (k == 5);
      digest_q.push_back(e);
    end
    hash_restart();
  endtask

  // step to the next falling edge, with a random idle burst in front of it
  // outside the quiet tail
  task automatic maybe_idle_in();
    int n;
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      in_chan.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // drop the request line before a pause in sending
  task automatic stop_in();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  // drive one request and wait for it to be taken
  task automatic send_word(input logic [63:0] msg, input logic [3:0] nb,
                           input logic fin);
    maybe_idle_in();
    in_chan.valid        <= 1'b1;
    in_chan.message_word <= msg;
    in_chan.valid_bytes  <= nb;
    in_chan.final_word   <= fin;
    do @(posedge clk); while (!in_chan.ready);
    predict_word(msg, nb, fin);
    words_sent++;
    if (fin) messages_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random message: mostly short, a few spanning several blocks
  task automatic send_message(input int nwords);
    logic [3:0] nb;
    for (int i = 0; i < nwords; i++) begin
      send_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
    end
    nb = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send_word(rand64(), nb, 1'b1);
  endtask

  // result side: random stalls, one long hold-off, field checks
  initial begin
    int n;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_chan.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 8);
        out_chan.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    digest_exp_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", out_chan.digest_word);
      end else begin
        e = digest_q.pop_front();
        // typed-in value for the first word of a directed message
        if (first_check) begin
          first_check = 1'b0;
          if (e.word !== first_expect) begin
            mismatches++;
            if (mismatches <= 10)
              $display("table value %h differs from predictor %h", first_expect, e.word);
          end
        end
        if (out_chan.digest_word !== e.word || out_chan.digest_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h/%b got %h/%b", e.word, e.last,
                     out_chan.digest_word, out_chan.digest_last);
        end
      end
    end
  end

  // watchdog on cycles where no request moves
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= MaxIdleCycles) begin
        $display("watchdog: no progress");
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // directed table: empty message, known digests, every valid count, saturation
  stim_row_t dir_tbl[$];

  task automatic add_row(input logic [63:0] m, input logic [3:0] nb, input logic f,
                         input logic [63:0] fw, input logic hf);
    stim_row_t r;
    r.msg = m; r.nbytes = nb; r.fin = f; r.first_word = fw; r.has_first = hf;
    dir_tbl.push_back(r);
  endtask

  initial begin
    int nw;
    in_chan.valid        = 1'b0;
    in_chan.message_word = '0;
    in_chan.valid_bytes  = '0;
    in_chan.final_word   = 1'b0;
    hash_restart();

    // empty message right after reset, known first digest word
    add_row(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 64'h38b060a751ac9638, 1'b1);
    // "abc", known first digest word
    add_row(64'h6162_6300_0000_0000, 4'd3, 1'b1, 64'hcb00753f45a35e8b, 1'b1);
    // full final word, marker in the next word
    add_row(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, '0, 1'b0);
    // count above eight saturates
    add_row(64'h0123_4567_89ab_cdef, 4'd15, 1'b1, '0, 1'b0);
    // every valid count once, after an all-zero non-final word
    for (int k = 0; k <= 8; k++) begin
      add_row(64'd0, 4'hf, 1'b0, '0, 1'b0);
      add_row(64'hfedc_ba98_7654_3210, 4'(k), 1'b1, '0, 1'b0);
    end

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].has_first) begin
        // let earlier digests drain so the typed value lines up
        stop_in();
        while (digest_q.size() != 0) @(negedge clk);
        first_expect = dir_tbl[i].first_word;
        first_check  = 1'b1;
      end
      send_word(dir_tbl[i].msg, dir_tbl[i].nbytes, dir_tbl[i].fin);
    end

    // marker in slot 14 and 15 cases: 14 and 15 words ahead of the final one
    send_message(14);
    send_message(15);

    // long receiver hold-off while the sender keeps offering messages
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(2);
        send_message(1);
        send_message(3);
      end
    join

    // random part
    while (words_sent < 410) begin
      if (words_sent > 360) quiet_tail = 1'b1;
      case ($urandom_range(0, 9))
        0:       nw = $urandom_range(16, 40);
        1, 2:    nw = $urandom_range(12, 17);
        default: nw = $urandom_range(0, 6);
      endcase
      send_message(nw);
    end
    quiet_tail = 1'b1;
    stop_in();

    while (digest_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("sent %0d message words in %0d messages, checked %0d digest words",
             words_sent, messages_sent, digests_seen);
    $display("covered all valid counts, saturation, block-boundary padding, long output stall");
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/s384_pkg.sv
design/s384_if.sv
design/s384_core.sv
design/sha384_hash_top.sv
tb/sha384_hash_top_tb.sv
